// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/cds_pkg.sv =====
package cds_pkg;

	localparam logic [1:0] OP_FWD  = 2'd0;
	localparam logic [1:0] OP_BACK = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	localparam logic [13:0] YEAR_MIN = 14'd1;
	localparam logic [13:0] YEAR_MAX = 14'd9999;

	localparam logic [13:0] RST_YEAR    = 14'd2000;
	localparam logic [3:0]  RST_MONTH   = 4'd1;
	localparam logic [4:0]  RST_DAY     = 5'd1;
	localparam logic [2:0]  RST_WEEKDAY = 3'd6;
	// 2000 mod 400.
	localparam logic [8:0]  RST_YR400   = 9'd0;

	// floor(y / 100) = (y * RECIP_100_400) >> 20 and floor(y / 400) = ... >> 22
	// for every 14-bit y.
	localparam logic [13:0] RECIP_100_400 = 14'd10486;

	typedef struct packed {
		logic [1:0]  op;
		logic [13:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
	} cmd_t;

	typedef struct packed {
		logic [13:0] cur_year;
		logic [3:0]  cur_month;
		logic [4:0]  cur_day;
		logic [2:0]  weekday;
		logic        error;
	} res_t;

	// Leap test from the year taken modulo 400.
	function automatic logic is_leap(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// Length of a month; zero for a month code outside 1 to 12.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// (13 * m + 8) / 5 for the shifted month 3 to 14.
	function automatic logic [5:0] month_term(input logic [4:0] m);
		logic [5:0] t;
		case (m)
			5'd3:  t = 6'd9;
			5'd4:  t = 6'd12;
			5'd5:  t = 6'd14;
			5'd6:  t = 6'd17;
			5'd7:  t = 6'd19;
			5'd8:  t = 6'd22;
			5'd9:  t = 6'd25;
			5'd10: t = 6'd27;
			5'd11: t = 6'd30;
			5'd12: t = 6'd32;
			5'd13: t = 6'd35;
			5'd14: t = 6'd38;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/calendar_date_stepper.sv =====
// A command beat passes stages 1 to 4, then the result register, and a stalled result
// holds it back. Throughput: one command per cycle while res_stall is low; the date and
// weekday update is a loop on the state in the last stage, the load weekday is pipelined ahead.
// Reset: pipeline empty, no result pending, date 2000-01-01, weekday Saturday.
`include "assert_macros.svh"

module calendar_date_stepper (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  cds_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output cds_pkg::res_t res
);

	// Stage registers.
	logic          v_s1, v_s2, v_s3, v_s4;
	cds_pkg::cmd_t c_s1, c_s2, c_s3, c_s4;
	logic [13:0]   ya_s2;
	logic [4:0]    mm_s2;
	logic [27:0]   prod_s2;
	logic [14:0]   sum_s3;
	logic [8:0]    yr400_s3;
	logic [2:0]    wd_s4;
	logic [8:0]    yr400_s4;
	logic          ok_s4;

	// Architectural state and result.
	logic          res_valid_q;
	logic          err_q;
	logic [13:0]   year_q;
	logic [3:0]    month_q;
	logic [4:0]    day_q;
	logic [2:0]    weekday_q;
	logic [8:0]    yr400_q;

	logic rdy_res, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	logic fire_s4;

	assign rdy_res   = !res_valid_q || !res_stall;
	assign rdy_s4    = !v_s4 || rdy_res;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd_stall = !rdy_s1;
	assign fire_s4   = v_s4 && rdy_res;

	// Stage 1 to 2: shift Jan/Feb into the previous year and multiply once
	// for both the /100 and /400 quotients.
	logic [13:0] ya_d;
	logic [4:0]  mm_d;
	logic [27:0] prod_d;

	always_comb begin
		if (c_s1.load_month < 4'd3) begin
			ya_d = c_s1.load_year - 14'd1;
			mm_d = {1'b0, c_s1.load_month} + 5'd12;
		end else begin
			ya_d = c_s1.load_year;
			mm_d = {1'b0, c_s1.load_month};
		end
		prod_d = 28'(ya_d) * 28'(cds_pkg::RECIP_100_400);
	end

	// Stage 2 to 3: weekday sum before the modulo, and the load year mod 400.
	logic [7:0]  q100;
	logic [5:0]  q400;
	logic [8:0]  ra;
	logic [8:0]  yr400_d;
	logic [14:0] sum_d;

	always_comb begin
		q100 = prod_s2[27:20];
		q400 = prod_s2[27:22];
		ra   = 9'(ya_s2 - 14'(q400) * 14'd400);
		if (c_s2.load_month < 4'd3) begin
			yr400_d = (ra == 9'd399) ? 9'd0 : ra + 9'd1;
		end else begin
			yr400_d = ra;
		end
		sum_d = 15'(ya_s2) + 15'(ya_s2[13:2]) - 15'(q100) + 15'(q400)
			+ 15'(cds_pkg::month_term(mm_s2)) + 15'(c_s2.load_day);
	end

	// Stage 3 to 4: sum mod 7 by folding octal digits (8 = 1 mod 7), and the
	// load date check.
	logic [5:0] fold1;
	logic [3:0] fold2;
	logic [2:0] wd_d;
	logic       ok_d;

	always_comb begin
		fold1 = 6'(sum_s3[14:12]) + 6'(sum_s3[11:9]) + 6'(sum_s3[8:6])
			+ 6'(sum_s3[5:3]) + 6'(sum_s3[2:0]);
		fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
		wd_d  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
		ok_d  = (c_s3.load_year >= cds_pkg::YEAR_MIN)
			&& (c_s3.load_year <= cds_pkg::YEAR_MAX)
			&& (c_s3.load_day >= 5'd1)
			&& (c_s3.load_day <= cds_pkg::month_days(c_s3.load_month,
				cds_pkg::is_leap(yr400_s3)));
	end

	// Stage 4: the date update loop.
	logic        leap_cur;
	logic [4:0]  len_cur;
	logic [3:0]  month_prev;
	logic [13:0] year_d;
	logic [3:0]  month_d;
	logic [4:0]  day_d;
	logic [2:0]  weekday_d;
	logic [8:0]  yr400_n;
	logic        err_d;

	always_comb begin
		leap_cur   = cds_pkg::is_leap(yr400_q);
		len_cur    = cds_pkg::month_days(month_q, leap_cur);
		month_prev = month_q - 4'd1;
		year_d     = year_q;
		month_d    = month_q;
		day_d      = day_q;
		weekday_d  = weekday_q;
		yr400_n    = yr400_q;
		err_d      = 1'b0;
		case (c_s4.op)
			cds_pkg::OP_FWD: begin
				if (day_q == len_cur && month_q == 4'd12 && year_q >= cds_pkg::YEAR_MAX) begin
					err_d = 1'b1;
				end else begin
					weekday_d = (weekday_q == 3'd6) ? 3'd0 : weekday_q + 3'd1;
					if (day_q != len_cur) begin
						day_d = day_q + 5'd1;
					end else if (month_q != 4'd12) begin
						month_d = month_q + 4'd1;
						day_d   = 5'd1;
					end else begin
						year_d  = year_q + 14'd1;
						month_d = 4'd1;
						day_d   = 5'd1;
						yr400_n = (yr400_q == 9'd399) ? 9'd0 : yr400_q + 9'd1;
					end
				end
			end
			cds_pkg::OP_BACK: begin
				if (day_q == 5'd1 && month_q == 4'd1 && year_q <= cds_pkg::YEAR_MIN) begin
					err_d = 1'b1;
				end else begin
					weekday_d = (weekday_q == 3'd0) ? 3'd6 : weekday_q - 3'd1;
					if (day_q != 5'd1) begin
						day_d = day_q - 5'd1;
					end else if (month_q != 4'd1) begin
						month_d = month_prev;
						day_d   = cds_pkg::month_days(month_prev, leap_cur);
					end else begin
						year_d  = year_q - 14'd1;
						month_d = 4'd12;
						day_d   = 5'd31;
						yr400_n = (yr400_q == 9'd0) ? 9'd399 : yr400_q - 9'd1;
					end
				end
			end
			cds_pkg::OP_LOAD: begin
				if (ok_s4) begin
					year_d    = c_s4.load_year;
					month_d   = c_s4.load_month;
					day_d     = c_s4.load_day;
					weekday_d = wd_s4;
					yr400_n   = yr400_s4;
				end else begin
					err_d = 1'b1;
				end
			end
			default: begin
				err_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
			err_q       <= 1'b0;
			year_q      <= cds_pkg::RST_YEAR;
			month_q     <= cds_pkg::RST_MONTH;
			day_q       <= cds_pkg::RST_DAY;
			weekday_q   <= cds_pkg::RST_WEEKDAY;
			yr400_q     <= cds_pkg::RST_YR400;
		end else begin
			if (rdy_s1) begin
				v_s1 <= cmd_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_res) begin
				res_valid_q <= v_s4;
			end
			if (fire_s4) begin
				err_q     <= err_d;
				year_q    <= year_d;
				month_q   <= month_d;
				day_q     <= day_d;
				weekday_q <= weekday_d;
				yr400_q   <= yr400_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && rdy_s1) begin
			c_s1 <= cmd;
		end
		if (v_s1 && rdy_s2) begin
			c_s2    <= c_s1;
			ya_s2   <= ya_d;
			mm_s2   <= mm_d;
			prod_s2 <= prod_d;
		end
		if (v_s2 && rdy_s3) begin
			c_s3     <= c_s2;
			sum_s3   <= sum_d;
			yr400_s3 <= yr400_d;
		end
		if (v_s3 && rdy_s4) begin
			c_s4     <= c_s3;
			wd_s4    <= wd_d;
			yr400_s4 <= yr400_s3;
			ok_s4    <= ok_d;
		end
	end

	// The result beat is the state itself, which only moves when a beat leaves the last stage.
	assign res_valid = res_valid_q;
	assign res = '{cur_year: year_q, cur_month: month_q, cur_day: day_q,
		weekday: weekday_q, error: err_q};

	`ASSERT_AT(a_date_legal, clk, arst_n, (month_q >= 4'd1) && (month_q <= 4'd12) && (day_q >= 5'd1) && (day_q <= len_cur), "held date is not a calendar date")
	`ASSERT_AT(a_year_range, clk, arst_n, (year_q >= cds_pkg::YEAR_MIN) && (year_q <= cds_pkg::YEAR_MAX), "held year out of range")
	`ASSERT_AT(a_err_keeps_state, clk, arst_n, (fire_s4 && err_d) |=> ($stable(year_q) && $stable(month_q) && $stable(day_q) && $stable(weekday_q)), "state changed on an error")
	`ASSERT_AT(a_idle_keeps_state, clk, arst_n, !fire_s4 |=> ($stable(year_q) && $stable(yr400_q) && $stable(err_q)), "state changed without a beat in the last stage")
	`ASSERT_NEVER(a_stall_needs_full, clk, arst_n, cmd_stall && !(v_s1 && v_s2 && v_s3 && v_s4 && res_valid_q), "command stalled while the pipeline has room")

endmodule
